// ===== hw/rtl/isv_pkg.sv =====
// isv_pkg: shared types for the indexed stack vector
// request codes, status codes, controller states and control structs
// no dependencies
package isv_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_SET    = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_EXEC     = 3'd1,
    S_GET_WAIT = 3'd2,
    S_SH_RD    = 3'd3,
    S_SH_WR    = 3'd4
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture request word
    logic rd_shift;  // read address from shift pointer
    logic ptr_load;  // shift pointer <= index + 1
    logic ptr_inc;   // shift pointer advances
    logic wr_shift;  // write read data one slot down
    logic commit;    // apply update and publish result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_e req;
    logic ok;          // decoded status is ok
    logic shift_more;  // remove has elements above the index
    logic last;        // shift pointer is on the top element
  } dp_stat_t;

endpackage

// ===== hw/rtl/isv_ram.sv =====
// isv_ram: generic single write port RAM with registered read
// no dependencies
module isv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/isv_ctrl.sv =====
// isv_ctrl: sequencing state machine of the indexed stack vector
// depends on isv_pkg
module isv_ctrl
  import isv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.req == REQ_GET && stat_i.ok) begin
          state_d = S_GET_WAIT;
        end else if (stat_i.req == REQ_REMOVE && stat_i.ok && stat_i.shift_more) begin
          state_d = S_SH_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_GET_WAIT: state_d = S_IDLE;
      S_SH_RD:    state_d = S_SH_WR;
      S_SH_WR: begin
        state_d = stat_i.last ? S_IDLE : S_SH_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = start;
      end
      S_EXEC: begin
        if (stat_i.req == REQ_GET && stat_i.ok) begin
          cmd_o.commit = 1'b0;
        end else if (stat_i.req == REQ_REMOVE && stat_i.ok && stat_i.shift_more) begin
          cmd_o.ptr_load = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
        end
      end
      S_GET_WAIT: cmd_o.commit = 1'b1;
      S_SH_RD:    cmd_o.rd_shift = 1'b1;
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        cmd_o.commit   = stat_i.last;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  a_start_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> (state_q == S_EXEC))
    else $error("accepted request did not reach execute");

  a_shift_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_RD) |=> (state_q == S_SH_WR))
    else $error("shift read not followed by shift write");

endmodule

// ===== hw/rtl/isv_dp.sv =====
// isv_dp: datapath of the indexed stack vector
// request registers, element count, shift pointer, result registers, element RAM
// depends on isv_pkg and isv_ram
module isv_dp
  import isv_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  elem_index_i,
  input  logic [31:0] elem_value_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [6:0]  count_after_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  req_e                  req_q;
  logic [5:0]            idx_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q;
  logic                  done_q;
  logic [31:0]           rv_q, rv_d;
  status_e               st_q, st;
  logic [6:0]            cnt_out_q;

  logic                  idx_ge;
  logic [63:0]           val_ext, rdata_ext;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [31:0]           cnt_ext;

  assign val_ext = 64'(elem_value_i);

  // request capture and shift pointer, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(req_type_i);
      idx_q <= elem_index_i;
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= AW'(32'(idx_q) + 32'd1);
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + AW'(1);
    end
  end

  // status decode
  assign idx_ge = (32'(idx_q) >= 32'(count_q));

  always_comb begin
    st = ST_OK;
    case (req_q)
      REQ_PUSH:   if (32'(count_q) >= 32'(CAPACITY)) st = ST_FULL;
      REQ_POP:    if (count_q == '0) st = ST_EMPTY;
      REQ_REMOVE: begin
        if (count_q == '0) begin
          st = ST_EMPTY;
        end else if (idx_ge) begin
          st = ST_RANGE;
        end
      end
      REQ_GET:    if (idx_ge) st = ST_RANGE;
      REQ_SET:    if (idx_ge) st = ST_RANGE;
      default:    st = ST_OK;
    endcase
  end

  assign stat_o.req        = req_q;
  assign stat_o.ok         = (st == ST_OK);
  assign stat_o.shift_more = ((32'(idx_q) + 32'd1) < 32'(count_q));
  assign stat_o.last       = ((32'(ptr_q) + 32'd1) >= 32'(count_q));

  // memory ports
  assign raddr = cmd_i.rd_shift ? ptr_q : AW'(32'(idx_q));

  always_comb begin
    we    = 1'b0;
    waddr = AW'(32'(idx_q));
    wdata = val_q;
    if (cmd_i.wr_shift) begin
      we    = 1'b1;
      waddr = ptr_q - AW'(1);
      wdata = rdata;
    end else if (cmd_i.commit && st == ST_OK) begin
      if (req_q == REQ_PUSH) begin
        we    = 1'b1;
        waddr = AW'(32'(count_q));
      end else if (req_q == REQ_SET) begin
        we    = 1'b1;
      end
    end
  end

  isv_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rdata_ext = 64'(rdata);

  // count update and result word
  always_comb begin
    count_d = count_q;
    rv_d    = '0;
    if (st == ST_OK) begin
      case (req_q)
        REQ_PUSH:   count_d = count_q + CW'(1);
        REQ_POP:    count_d = count_q - CW'(1);
        REQ_REMOVE: count_d = count_q - CW'(1);
        REQ_GET:    rv_d    = rdata_ext[31:0];
        REQ_CLEAR:  count_d = '0;
        default:    count_d = count_q;
      endcase
    end
  end

  assign cnt_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rv_q      <= rv_d;
      st_q      <= st;
      cnt_out_q <= cnt_ext[6:0];
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = rv_q;
  assign status_o      = st_q;
  assign count_after_o = cnt_out_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY))
    else $error("element count above capacity");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held two cycles");

  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && st == ST_FULL) |-> (32'(count_q) == 32'(CAPACITY)))
    else $error("full status below capacity");

endmodule

// ===== hw/rtl/indexed_stack_vector.sv =====
// indexed_stack_vector: top level of a bounded vector store
// depends on isv_pkg, isv_ctrl, isv_dp (which holds isv_ram)
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  request   | start in, busy out     | req_type_i, elem_index_i, elem_value_i
//  result    | done_o strobe, 1 cycle | read_value_o, status_o, count_after_o
//
// an accepted word is decoded in the next cycle; push, pop, set, clear,
// unused codes, a remove of the top element and rejected requests strobe
// their result in the cycle after that; get first waits in S_GET_WAIT for
// the registered RAM read; remove at index k with n elements alternates S_SH_RD
// and S_SH_WR, one RAM read and one write per moved element above k
// reset clears the element count and the controller; RAM contents stay
// undefined and need no clearing pass since reads stay below the count
// results cannot be held off; the next word is taken while one is shown
module indexed_stack_vector
  import isv_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  elem_index_i,
  input  logic [31:0] elem_value_i,
  // result side
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [6:0]  count_after_o
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: decode, get wait, remove shift loop
  isv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: request regs, count, shift pointer, element RAM, result regs
  isv_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .elem_index_i  (elem_index_i),
    .elem_value_i  (elem_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .count_after_o (count_after_o)
  );

endmodule

// ===== verif/isv_checker.sv =====
// isv_checker: watches the request and result channels of the indexed stack vector,
// predicts every result word and compares it field by field
// depends on isv_pkg for request and status codes
module isv_checker
  import isv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  elem_index_i,
  input  logic [31:0] elem_value_i,
  input  logic        done_i,
  input  logic [31:0] read_value_i,
  input  logic [1:0]  status_i,
  input  logic [6:0]  count_after_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int CAPACITY = 64;

  typedef struct packed {
    logic [31:0] read_value;
    status_e     status;
    logic [6:0]  count_after;
  } vec_result_t;

  logic [31:0] elems [CAPACITY];
  int          elem_cnt;
  vec_result_t due_results [$];

  // apply one request to the shadow vector and return its result word
  function automatic vec_result_t apply_request(input logic [2:0] kind,
                                                input logic [5:0] ix,
                                                input logic [31:0] val);
    vec_result_t r;
    r.read_value = '0;
    r.status     = ST_OK;
    case (kind)
      REQ_PUSH: begin
        if (elem_cnt >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          elems[elem_cnt] = val;
          elem_cnt++;
        end
      end
      REQ_POP: begin
        if (elem_cnt == 0) r.status = ST_EMPTY;
        else elem_cnt--;
      end
      REQ_REMOVE: begin
        if (elem_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(ix) >= elem_cnt) begin
          r.status = ST_RANGE;
        end else begin
          // close the gap: everything above the index slides down one slot
          for (int i = int'(ix) + 1; i < elem_cnt; i++) elems[i-1] = elems[i];
          elem_cnt--;
        end
      end
      REQ_GET: begin
        if (int'(ix) >= elem_cnt) r.status = ST_RANGE;
        else r.read_value = elems[ix];
      end
      REQ_SET: begin
        if (int'(ix) >= elem_cnt) r.status = ST_RANGE;
        else elems[ix] = val;
      end
      REQ_CLEAR: elem_cnt = 0;
      default: ;
    endcase
    r.count_after = elem_cnt[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t want;
    if (!rst_ni) begin
      elem_cnt = 0;
      due_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got value %h status %0d count %0d",
                   $time, read_value_i, status_i, count_after_i);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (read_value_i !== want.read_value) begin
            $display("%0t: read_value expected %h, got %h", $time, want.read_value,
                     read_value_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (count_after_i !== want.count_after) begin
            $display("%0t: count_after expected %0d, got %0d", $time, want.count_after,
                     count_after_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        due_results.push_back(apply_request(req_type_i, elem_index_i, elem_value_i));
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== verif/indexed_stack_vector_tb.sv =====
// indexed_stack_vector_tb: drives directed and random request words into the vector
// store and gives the verdict; prediction and comparison live in isv_checker
// depends on isv_pkg, isv_checker and the indexed_stack_vector RTL
module indexed_stack_vector_tb;
  import isv_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int WATCHDOG_LIMIT = 2000;  // covers the longest remove, sender gaps are short
  localparam int DRAIN_CYCLES   = 200;
  localparam int PHASE_WORDS    = 284;   // random words in each of the three phases

  // codes six and seven are not part of req_e; the block must ignore them
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [5:0]  elem_index_i;
  logic [31:0] elem_value_i;
  logic        done_o;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;
  logic [6:0]  count_after_o;

  int fail_count;
  int pending;
  int stall_cycles;

  // stimulus state: idle rate of the sender, rough length and where we steer it
  int idle_pct;
  int vec_len;
  int fill_goal;

  indexed_stack_vector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_after_o(count_after_o)
  );

  isv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_type_i   (req_type_i),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .done_i       (done_o),
    .read_value_i (read_value_o),
    .status_i     (status_o),
    .count_after_i(count_after_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog: any stretch with neither a word taken nor a result shown is a hang
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one request word, holding start until the block takes it;
  // returns just after the accepting edge so the next word can follow at once
  task automatic send_word(input logic [2:0] kind, input logic [5:0] ix,
                           input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= kind;
    elem_index_i <= ix;
    elem_value_i <= val;
    // busy only moves on rising edges, so the value at the falling edge decides
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    // rough length, only used to steer the random part
    case (kind)
      REQ_PUSH:   if (vec_len < CAPACITY) vec_len++;
      REQ_POP:    if (vec_len > 0) vec_len--;
      REQ_REMOVE: if (vec_len > 0 && int'(ix) < vec_len) vec_len--;
      REQ_CLEAR:  vec_len = 0;
      default: ;
    endcase
  endtask

  // mostly indexes that hit a live element, sometimes anything at all
  function automatic logic [5:0] pick_index();
    if (vec_len > 0 && $urandom_range(99) < 85) return 6'($urandom_range(vec_len - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one random word: most of the mix steers the length toward fill_goal so
  // that full, empty and every depth in between get visited
  task automatic send_random_word();
    logic [2:0] kind;
    int         r;
    r = $urandom_range(99);
    if (r < 60) begin
      if (vec_len < fill_goal) kind = REQ_PUSH;
      else if (vec_len > fill_goal) kind = REQ_POP;
      else if (fill_goal == 0) kind = REQ_POP;             // pop on empty
      else if (fill_goal >= CAPACITY) kind = REQ_PUSH;     // push on full
      else kind = $urandom_range(1) ? REQ_PUSH : REQ_POP;
    end else if (r < 68) kind = REQ_REMOVE;
    else if (r < 78) kind = REQ_GET;
    else if (r < 88) kind = REQ_SET;
    else if (r < 92) kind = REQ_PUSH;
    else if (r < 95) kind = REQ_POP;
    else if (r < 97) kind = (vec_len > fill_goal) ? REQ_CLEAR : REQ_GET;
    else kind = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
    send_word(kind, pick_index(), pick_value());
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_PUSH;
    elem_index_i = '0;
    elem_value_i = '0;
    idle_pct     = 31;
    vec_len      = 0;
    fill_goal    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-vector corner cases first
    send_word(REQ_POP,    6'd0,  32'h1234_5678);   // pop on empty
    send_word(REQ_REMOVE, 6'd5,  32'h0);           // remove on empty beats range check
    send_word(REQ_GET,    6'd0,  32'h0);           // get on empty is out of range
    send_word(REQ_SET,    6'd63, 32'hdead_beef);   // set on empty is out of range
    // value extremes and a few reads
    send_word(REQ_PUSH,   6'd0,  32'h0000_0000);
    send_word(REQ_PUSH,   6'd63, 32'hffff_ffff);
    send_word(REQ_PUSH,   6'd0,  32'ha5a5_a5a5);
    send_word(REQ_GET,    6'd0,  32'h0);
    send_word(REQ_GET,    6'd2,  32'h0);
    send_word(REQ_GET,    6'd3,  32'h0);           // index equal to length
    send_word(REQ_SET,    6'd1,  32'h5a5a_5a5a);
    send_word(REQ_GET,    6'd1,  32'h0);
    send_word(REQ_REMOVE, 6'd63, 32'h0);           // remove out of range
    send_word(REQ_REMOVE, 6'd2,  32'h0);           // remove top element, nothing moves
    send_word(REQ_REMOVE, 6'd0,  32'h0);           // remove bottom, one element slides
    send_word(REQ_GET,    6'd0,  32'h0);
    send_word(REQ_UNUSED_LO, 6'd0,  32'hffff_ffff);
    send_word(REQ_UNUSED_HI, 6'd63, 32'hffff_ffff);
    send_word(REQ_PUSH,   6'd0,  32'h8000_0001);
    send_word(REQ_CLEAR,  6'd0,  32'h0);
    send_word(REQ_POP,    6'd0,  32'h0);           // empty again after clear
    send_word(REQ_PUSH,   6'd0,  32'h0000_00ff);
    send_word(REQ_GET,    6'd0,  32'h0);

    // random: sender idles 31 percent, then 69 percent, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 69 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 100 == 0) begin
          case ($urandom_range(5))
            0:       fill_goal = 0;
            1, 2:    fill_goal = CAPACITY;
            3:       fill_goal = $urandom_range(8, 1);
            default: fill_goal = $urandom_range(CAPACITY);
          endcase
        end
        send_random_word();
      end
    end
    start <= 1'b0;

    // drain outstanding results, then wait so that a stray result strobe is caught
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/isv_pkg.sv
hw/rtl/isv_ram.sv
hw/rtl/isv_ctrl.sv
hw/rtl/isv_dp.sv
hw/rtl/indexed_stack_vector.sv
verif/isv_checker.sv
verif/indexed_stack_vector_tb.sv
